// ===== hw/rtl/tpq_pkg.sv =====
`default_nettype none

package tpq_pkg;

  localparam int unsigned TagW   = 16;
  localparam int unsigned ClassW = 2;
  localparam int unsigned OccW   = 5;
  localparam int unsigned NumClasses = 3;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEND   = 1'b1;

  localparam logic [ClassW-1:0] CLASS_INSTANT  = 2'd0;
  localparam logic [ClassW-1:0] CLASS_STANDARD = 2'd1;
  localparam logic [ClassW-1:0] CLASS_ECONOMY  = 2'd2;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_SENT     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic              command;
    logic [ClassW-1:0] priority_class;
    logic [TagW-1:0]   package_tag;
  } tpq_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ClassW-1:0] out_class;
    logic [TagW-1:0]   out_tag;
    logic [OccW-1:0]   occupancy;
  } tpq_out_t;

  typedef struct packed {
    logic exec;
    logic is_send;
    logic do_insert;
    logic do_send;
  } tpq_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tpq_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tpq_ram.sv =====
`default_nettype none

module tpq_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tpq_ctrl.sv =====
`default_nettype none

module tpq_ctrl
  import tpq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  wire logic      command_i,
  input  wire tpq_stat_t stat_i,
  output tpq_ctrl_t      ctrl_o,
  output logic           busy,
  output logic           done_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);
  assign accept = start && !busy;

  always_comb begin
    ctrl_o.exec      = accept;
    ctrl_o.is_send   = (command_i == CMD_SEND);
    ctrl_o.do_insert = accept && (command_i == CMD_INSERT) && !stat_i.full;
    ctrl_o.do_send   = accept && (command_i == CMD_SEND) && !stat_i.empty;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_RESP;
        end
      end
      S_RESP: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tpq_datapath.sv =====
`default_nettype none

module tpq_datapath
  import tpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire tpq_in_t   in_i,
  input  wire tpq_ctrl_t ctrl_i,
  output tpq_stat_t      stat_o,
  output tpq_out_t       out_o
);

  localparam int unsigned PtrW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]   total_q;
  logic [CntW-1:0]   cnt_q   [NumClasses];
  logic [PtrW-1:0]   head_q  [NumClasses];
  logic [PtrW-1:0]   tail_q  [NumClasses];
  logic [TagW-1:0]   rdata   [NumClasses];
  logic [ClassW-1:0] cls_in;
  logic [ClassW-1:0] sel_cls;
  logic [ClassW-1:0] ocls_q;
  status_e           status_q;
  logic [TagW-1:0]   tag_out;
  logic [CntW+OccW-1:0] occ_ext;

  assign cls_in = (in_i.priority_class > CLASS_ECONOMY) ? CLASS_ECONOMY : in_i.priority_class;

  always_comb begin
    if (cnt_q[0] != '0) begin
      sel_cls = CLASS_INSTANT;
    end else if (cnt_q[1] != '0) begin
      sel_cls = CLASS_STANDARD;
    end else begin
      sel_cls = CLASS_ECONOMY;
    end
  end

  assign stat_o.full  = (total_q >= CntW'(CAPACITY));
  assign stat_o.empty = (total_q == '0);

  for (genvar c = 0; c < NumClasses; c++) begin : g_class
    logic wr;
    logic rd;

    assign wr = ctrl_i.do_insert && (cls_in == ClassW'(c));
    assign rd = ctrl_i.do_send && (sel_cls == ClassW'(c));

    tpq_ram #(
      .Width (TagW),
      .Depth (CAPACITY)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr),
      .waddr_i (tail_q[c]),
      .wdata_i (in_i.package_tag),
      .re_i    (rd),
      .raddr_i (head_q[c]),
      .rdata_o (rdata[c])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q[c]  <= '0;
        head_q[c] <= '0;
        tail_q[c] <= '0;
      end else if (wr) begin
        cnt_q[c]  <= cnt_q[c] + CntW'(1);
        tail_q[c] <= (tail_q[c] == PtrW'(CAPACITY - 1)) ? '0 : tail_q[c] + PtrW'(1);
      end else if (rd) begin
        cnt_q[c]  <= cnt_q[c] - CntW'(1);
        head_q[c] <= (head_q[c] == PtrW'(CAPACITY - 1)) ? '0 : head_q[c] + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (ctrl_i.do_insert) begin
      total_q <= total_q + CntW'(1);
    end else if (ctrl_i.do_send) begin
      total_q <= total_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      if (ctrl_i.do_insert) begin
        status_q <= ST_INSERTED;
        ocls_q   <= CLASS_INSTANT;
      end else if (ctrl_i.do_send) begin
        status_q <= ST_SENT;
        ocls_q   <= sel_cls;
      end else begin
        status_q <= ctrl_i.is_send ? ST_EMPTY : ST_FULL;
        ocls_q   <= CLASS_INSTANT;
      end
    end
  end

  always_comb begin
    tag_out = '0;
    if (status_q == ST_SENT) begin
      case (ocls_q)
        CLASS_INSTANT:  tag_out = rdata[0];
        CLASS_STANDARD: tag_out = rdata[1];
        CLASS_ECONOMY:  tag_out = rdata[2];
        default:        tag_out = '0;
      endcase
    end
  end

  assign occ_ext = {{OccW{1'b0}}, total_q};

  always_comb begin
    out_o.status    = status_q;
    out_o.out_class = ocls_q;
    out_o.out_tag   = tag_out;
    out_o.occupancy = occ_ext[OccW-1:0];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/three_class_priority_queue.sv =====
// Channel   Handshake            Payload    Word
// command   start / busy         cmd_i      command, priority_class, package_tag
// result    done_o (one cycle)   res_o      status, out_class, out_tag, occupancy
//
// Each command is accepted while busy is low, and its result word is shown
// with done_o in the next cycle, while busy is high; the result comes from the
// registered per-class RAM read. Reset empties all three class queues at once.
// The receiver cannot stall, so each result word is taken in its done_o cycle.
`default_nettype none

module three_class_priority_queue
  import tpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output logic         busy,
  input  wire tpq_in_t cmd_i,
  output logic         done_o,
  output tpq_out_t     res_o
);

  tpq_ctrl_t ctrl;
  tpq_stat_t stat;

  tpq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (cmd_i.command),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .busy      (busy),
    .done_o    (done_o)
  );

  tpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_i),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .out_o  (res_o)
  );

endmodule

`default_nettype wire

// ===== verif/tpq_tb_pkg.sv =====
package tpq_tb_pkg;

  import tpq_pkg::*;

  typedef struct packed {
    logic [ClassW-1:0] cls;
    logic [TagW-1:0]   tag;
  } parcel_t;

  class dispatch_scoreboard;

    int unsigned capacity;
    int unsigned failures;
    parcel_t     held_parcels[$];
    tpq_out_t    due_words[$];

    function new(int unsigned capacity_in);
      capacity = capacity_in;
      failures = 0;
    endfunction

    // Works out the result word of one command and updates the held parcels.
    function tpq_out_t predict_dispatch(tpq_in_t w);
      tpq_out_t    res;
      parcel_t     p;
      int unsigned pos;
      res = '0;
      if (w.command == CMD_INSERT) begin
        if (held_parcels.size() >= capacity) begin
          res.status = ST_FULL;
        end else begin
          p.cls = (w.priority_class > CLASS_ECONOMY) ? CLASS_ECONOMY : w.priority_class;
          p.tag = w.package_tag;
          pos = 0;
          while (pos < held_parcels.size() && held_parcels[pos].cls <= p.cls) begin
            pos++;
          end
          held_parcels.insert(pos, p);
          res.status = ST_INSERTED;
        end
      end else begin
        if (held_parcels.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          p = held_parcels.pop_front();
          res.status    = ST_SENT;
          res.out_class = p.cls;
          res.out_tag   = p.tag;
        end
      end
      res.occupancy = OccW'(held_parcels.size());
      return res;
    endfunction

    function void take_command(tpq_in_t w);
      due_words.push_back(predict_dispatch(w));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_word(tpq_out_t got);
      tpq_out_t want;
      if (due_words.size() == 0) begin
        $error("result word with no command pending: %h", got);
        failures++;
        return;
      end
      want = due_words.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("out_class", want.out_class, got.out_class);
      compare_field("out_tag", want.out_tag, got.out_tag);
      compare_field("occupancy", want.occupancy, got.occupancy);
    endfunction

    function int unsigned pending();
      return due_words.size();
    endfunction

  endclass

endpackage

// ===== verif/three_class_priority_queue_tb.sv =====
module three_class_priority_queue_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import tpq_pkg::*;
  import tpq_tb_pkg::*;

  localparam int unsigned Capacity    = 16;
  localparam int unsigned RandomWords = 800;
  localparam int unsigned CycleLimit  = 100000;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  tpq_in_t  cmd_i  = '0;
  logic     busy;
  logic     done_o;
  tpq_out_t res_o;

  int unsigned cycles = 0;

  dispatch_scoreboard sb = new(Capacity);

  three_class_priority_queue #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .cmd_i (cmd_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        sb.check_word(res_o);
      end
      if (start && !busy) begin
        sb.take_command(cmd_i);
      end
    end
  end

  // Holds the word on the port until the block takes it.
  task automatic put_word(input tpq_in_t w);
    start <= 1'b1;
    cmd_i <= w;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic pause(input int unsigned n);
    start <= 1'b0;
    repeat (n) begin
      cmd_i <= tpq_in_t'($urandom);
      @(posedge clk_i);
    end
  endtask

  function automatic tpq_in_t make_word(logic cmd, logic [ClassW-1:0] cls,
                                        logic [TagW-1:0] tag);
    tpq_in_t w;
    w.command        = cmd;
    w.priority_class = cls;
    w.package_tag    = tag;
    return w;
  endfunction

  function automatic tpq_in_t random_word(int unsigned insert_pct);
    logic [TagW-1:0] tag;
    logic            cmd;
    cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_SEND;
    case ($urandom_range(0, 9))
      0: tag = '0;
      1: tag = '1;
      default: tag = TagW'($urandom_range(0, 65535));
    endcase
    return make_word(cmd, ClassW'($urandom_range(0, 3)), tag);
  endfunction

  initial begin
    int unsigned issued;
    int unsigned burst;
    int unsigned insert_pct;
    int unsigned k;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    pause(2);

    put_word(make_word(CMD_SEND, ClassW'($urandom_range(0, 3)), TagW'($urandom)));
    put_word(make_word(CMD_INSERT, CLASS_ECONOMY, 16'h0000));
    put_word(make_word(CMD_INSERT, 2'd3, 16'hFFFF));
    put_word(make_word(CMD_INSERT, CLASS_STANDARD, 16'h1234));
    put_word(make_word(CMD_INSERT, CLASS_INSTANT, 16'hA5A5));
    pause(1);
    put_word(make_word(CMD_INSERT, CLASS_INSTANT, 16'h5A5A));
    put_word(make_word(CMD_SEND, 2'd3, 16'hFFFF));
    put_word(make_word(CMD_SEND, CLASS_INSTANT, 16'h0000));
    put_word(make_word(CMD_SEND, CLASS_STANDARD, 16'hFFFF));
    pause(3);
    for (k = 0; k < Capacity - 2; k++) begin
      put_word(make_word(CMD_INSERT, ClassW'($urandom_range(0, 3)), TagW'($urandom)));
    end
    put_word(make_word(CMD_INSERT, CLASS_INSTANT, 16'hBEEF));
    pause(2);

    issued = 0;
    while (issued < RandomWords) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      case ($urandom_range(0, 4))
        0: insert_pct = 90;
        1: insert_pct = 70;
        2: insert_pct = 50;
        3: insert_pct = 30;
        default: insert_pct = 10;
      endcase
      for (k = 0; k < burst; k++) begin
        put_word(random_word(insert_pct));
        issued++;
      end
      if ($urandom_range(0, 3) != 0) begin
        pause($urandom_range(1, 6));
      end
    end

    pause(1);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tpq_pkg.sv
hw/rtl/tpq_ram.sv
hw/rtl/tpq_ctrl.sv
hw/rtl/tpq_datapath.sv
hw/rtl/three_class_priority_queue.sv
verif/tpq_tb_pkg.sv
verif/three_class_priority_queue_tb.sv
